// ----- sv/sptrim_pkg.sv -----
// Shared types, register map and helpers for the string pattern trimmer.
// Used by the register block, the back end and the top level; depends on nothing.
`default_nettype none

package sptrim_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] REG_TRIM_MODE      = 2'd0;
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

    localparam logic [1:0] MODE_BOTH     = 2'd0;
    localparam logic [1:0] MODE_LEADING  = 2'd1;
    localparam logic [1:0] MODE_TRAILING = 2'd2;

    localparam logic [1:0]  RST_TRIM_MODE      = MODE_BOTH;
    localparam logic [63:0] RST_PATTERN_BYTES  = 64'h20;
    localparam logic [3:0]  RST_PATTERN_LENGTH = 4'd1;

    typedef struct packed {
        logic [1:0]  trim_mode;
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
    } cfg_t;

    function automatic logic [7:0] pattern_at(input logic [63:0] pat, input logic [2:0] idx);
        pattern_at = pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- sv/sptrim_in_if.sv -----
// Input channel of the string pattern trimmer: one text byte per transfer.
// Depends on nothing.
`default_nettype none

interface sptrim_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;
    logic       is_empty;

    modport source (output valid, output text_byte, output last_byte, output is_empty,
                    input ready);
    modport sink (input valid, input text_byte, input last_byte, input is_empty,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/sptrim_out_if.sv -----
// Output channel of the string pattern trimmer: one result byte per transfer.
// Depends on nothing.
`default_nettype none

interface sptrim_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    logic       empty_result;
    logic       too_long;

    modport source (output valid, output out_byte, output last_out, output empty_result,
                    output too_long, input ready);
    modport sink (input valid, input out_byte, input last_out, input empty_result,
                  input too_long, output ready);
endinterface

`default_nettype wire

// ----- sv/sptrim_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module sptrim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/sptrim_regs.sv -----
// APB-style configuration registers of the string pattern trimmer.
// Depends on sptrim_pkg.
`default_nettype none

module sptrim_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sptrim_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sptrim_pkg::PDATA_W-1:0] pwdata,
    output logic      [sptrim_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output sptrim_pkg::cfg_t                   cfg
);

    logic [1:0]  mode_reg;
    logic [63:0] pat_reg;
    logic [3:0]  plen_reg;
    logic        wr;
    logic [1:0]  sel;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign sel    = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sptrim_pkg::RST_TRIM_MODE;
            pat_reg  <= sptrim_pkg::RST_PATTERN_BYTES;
            plen_reg <= sptrim_pkg::RST_PATTERN_LENGTH;
        end
        else if (wr)
        begin
            case (sel)
                sptrim_pkg::REG_TRIM_MODE:      mode_reg <= pwdata[1:0];
                sptrim_pkg::REG_PATTERN_BYTES:  pat_reg  <= pwdata;
                sptrim_pkg::REG_PATTERN_LENGTH: plen_reg <= pwdata[3:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            sptrim_pkg::REG_TRIM_MODE:      prdata = {62'd0, mode_reg};
            sptrim_pkg::REG_PATTERN_BYTES:  prdata = pat_reg;
            sptrim_pkg::REG_PATTERN_LENGTH: prdata = {60'd0, plen_reg};
            default:                        prdata = '0;
        endcase
    end

    assign cfg.trim_mode      = mode_reg;
    assign cfg.pattern_bytes  = pat_reg;
    assign cfg.pattern_length = plen_reg;

endmodule

`default_nettype wire

// ----- sv/sptrim_front.sv -----
// Front end: accepts text bytes, writes them into the current buffer bank and
// issues a job descriptor at the end of each string. Depends on sptrim_in_if.
`default_nettype none

module sptrim_front #(
    parameter int MAX_LEN = 64,
    parameter int CW      = 7,
    parameter int AW      = 6
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sptrim_in_if.sink            text_in,
    input  wire logic            q_full,
    output logic                 wr_en,
    output logic [AW:0]          wr_addr,
    output logic [7:0]           wr_data,
    output logic                 push,
    output logic [CW+1:0]        push_data
);

    logic          cnt_lt;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          bank_reg, bank_next;
    logic          acc;
    logic          store;
    logic          fin;

    assign text_in.ready = !q_full;
    assign acc    = text_in.valid && !q_full;
    assign cnt_lt = cnt_reg < CW'(MAX_LEN);
    assign store  = acc && !text_in.is_empty && cnt_lt;
    assign fin    = acc && (text_in.last_byte || text_in.is_empty);

    assign wr_en   = store;
    assign wr_addr = {bank_reg, cnt_reg[AW-1:0]};
    assign wr_data = text_in.text_byte;

    always_comb
    begin
        cnt_next  = store ? cnt_reg + CW'(1) : cnt_reg;
        ovf_next  = ovf_reg || (acc && !text_in.is_empty && !cnt_lt);
        bank_next = bank_reg;
        push      = fin;
        push_data = {bank_reg, cnt_next, ovf_next};
        if (fin)
        begin
            cnt_next  = '0;
            ovf_next  = 1'b0;
            bank_next = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sptrim_jobq.sv -----
// Two-entry job queue between the front and back ends.
// Depends on nothing.
`default_nettype none

module sptrim_jobq #(
    parameter int W = 9
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              full,
    output logic              head_valid,
    output logic [W-1:0]      head_data
);

    logic [W-1:0] slot_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head_data  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sptrim_back.sv -----
// Back end: scans a buffered string for whole pattern copies at the front and/or
// the back, then emits the remaining bytes. Depends on sptrim_pkg, sptrim_out_if.
`default_nettype none

module sptrim_back #(
    parameter int MAX_PATTERN = 8,
    parameter int CW          = 7,
    parameter int AW          = 6
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sptrim_pkg::cfg_t cfg,
    input  wire logic            job_valid,
    input  wire logic [CW+1:0]   job_data,
    output logic                 pop,
    output logic                 rd_en,
    output logic [AW:0]          rd_addr,
    input  wire logic [7:0]      rd_data,
    sptrim_out_if.source         text_out
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW = $clog2(MAX_PATTERN + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LRD    = 4'd1;
    localparam logic [3:0] S_LCMP   = 4'd2;
    localparam logic [3:0] S_TRD    = 4'd3;
    localparam logic [3:0] S_TCMP   = 4'd4;
    localparam logic [3:0] S_ESTART = 4'd5;
    localparam logic [3:0] S_EMPTY  = 4'd6;
    localparam logic [3:0] S_ERD    = 4'd7;
    localparam logic [3:0] S_EOUT   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] front_reg, front_next;
    logic [CW-1:0] back_reg, back_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic          trail_reg, trail_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic          out_long_reg;

    logic          job_bank;
    logic [CW-1:0] job_len;
    logic          job_ovf;
    logic [PW-1:0] plen_clamp;
    logic [CW:0]   front_plus;
    logic [CW-1:0] back_base;
    logic [CW-1:0] lsum;
    logic [CW-1:0] tsum;
    logic          byte_hit;
    logic          pat_end;
    logic          out_free;
    logic          load;
    logic [7:0]    ld_byte;
    logic          ld_last;
    logic          ld_empty;

    assign job_bank   = job_data[CW+1];
    assign job_len    = job_data[CW:1];
    assign job_ovf    = job_data[0];
    assign plen_clamp = (cfg.pattern_length > 4'(MAX_PATTERN)) ? PW'(MAX_PATTERN)
                                                               : PW'(cfg.pattern_length);
    assign front_plus = {1'b0, front_reg} + (CW+1)'(plen_reg);
    assign back_base  = back_reg - CW'(plen_reg);
    assign lsum       = front_reg + CW'(idx_reg);
    assign tsum       = back_base + CW'(idx_reg);
    assign byte_hit   = rd_data == sptrim_pkg::pattern_at(cfg.pattern_bytes, 3'(idx_reg));
    assign pat_end    = (PW'(idx_reg) + PW'(1)) == plen_reg;
    assign out_free   = !out_valid_reg || text_out.ready;

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        back_next  = back_reg;
        idx_next   = idx_reg;
        plen_next  = plen_reg;
        trail_next = trail_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = {job_bank, front_reg[AW-1:0]};
        load       = 1'b0;
        ld_byte    = 8'd0;
        ld_last    = 1'b0;
        ld_empty   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    plen_next  = plen_clamp;
                    front_next = '0;
                    back_next  = job_len;
                    idx_next   = '0;
                    trail_next = cfg.trim_mode != sptrim_pkg::MODE_LEADING;
                    if (plen_clamp == '0)
                    begin
                        state_next = S_ESTART;
                    end
                    else if (cfg.trim_mode != sptrim_pkg::MODE_TRAILING)
                    begin
                        state_next = S_LRD;
                    end
                    else
                    begin
                        state_next = S_TRD;
                    end
                end
            end
            S_LRD:
            begin
                if (front_plus <= {1'b0, job_len})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {job_bank, lsum[AW-1:0]};
                    state_next = S_LCMP;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = trail_reg ? S_TRD : S_ESTART;
                end
            end
            S_LCMP:
            begin
                if (byte_hit)
                begin
                    state_next = S_LRD;
                    if (pat_end)
                    begin
                        front_next = front_plus[CW-1:0];
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = trail_reg ? S_TRD : S_ESTART;
                end
            end
            S_TRD:
            begin
                if ({1'b0, back_reg} >= front_plus)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {job_bank, tsum[AW-1:0]};
                    state_next = S_TCMP;
                end
                else
                begin
                    state_next = S_ESTART;
                end
            end
            S_TCMP:
            begin
                if (byte_hit)
                begin
                    state_next = S_TRD;
                    if (pat_end)
                    begin
                        back_next = back_base;
                        idx_next  = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ESTART;
                end
            end
            S_ESTART:
            begin
                state_next = (back_reg <= front_reg) ? S_EMPTY : S_ERD;
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_last    = 1'b1;
                    ld_empty   = 1'b1;
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERD:
            begin
                rd_en      = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_byte    = rd_data;
                    ld_last    = (front_reg + CW'(1)) == back_reg;
                    front_next = front_reg + CW'(1);
                    if (ld_last)
                    begin
                        pop        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            idx_reg       <= '0;
            plen_reg      <= '0;
            trail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            idx_reg       <= idx_next;
            plen_reg      <= plen_next;
            trail_reg     <= trail_next;
            out_valid_reg <= load || (out_valid_reg && !text_out.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= ld_byte;
            out_last_reg  <= ld_last;
            out_empty_reg <= ld_empty;
            out_long_reg  <= job_ovf;
        end
    end

    assign text_out.valid        = out_valid_reg;
    assign text_out.out_byte     = out_byte_reg;
    assign text_out.last_out     = out_last_reg;
    assign text_out.empty_result = out_empty_reg;
    assign text_out.too_long     = out_long_reg;

endmodule

`default_nettype wire

// ----- sv/string_pattern_trimmer_core.sv -----
// Top level of the string pattern trimmer: front end, job queue, back end,
// two-bank string buffer and configuration registers. Depends on all other files.
//
// Usage: strings enter on text_in one byte per transfer; last_byte or is_empty
// ends a string. The trimmed bytes leave on text_out, one per transfer, the
// final one marked by last_out; an empty outcome is a single transfer with
// empty_result set. Bytes beyond MAX_LEN are dropped and too_long is set on
// every result of that string. Registers are written through the APB port.
// The front end takes one byte per cycle while a buffer bank is free; the
// buffer holds two strings, so one string loads while the previous is trimmed.
// The back end shares the single buffer read port for scanning and emission:
// each compared pattern byte passes a read state and then a compare state, and
// each result passes a read state and then an output state, one result at a
// time; a start state between scan and emission checks for an empty outcome.
// When the receiver stalls, the result stays in the output register and the
// back end waits; once both banks are full, text_in.ready drops.
// Reset empties the queue and buffer counts and restores the register values
// (trim both ends, pattern a single space).
`default_nettype none

module string_pattern_trimmer_core #(
    parameter int MAX_LEN     = 64,
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    sptrim_in_if.sink                           text_in,
    sptrim_out_if.source                        text_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sptrim_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sptrim_pkg::PDATA_W-1:0] pwdata,
    output logic      [sptrim_pkg::PDATA_W-1:0] prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int JW = CW + 2;

    sptrim_pkg::cfg_t cfg;
    logic             wr_en;
    logic [AW:0]      wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW:0]      rd_addr;
    logic [7:0]       rd_data;
    logic             push;
    logic [JW-1:0]    push_data;
    logic             pop;
    logic             q_full;
    logic             job_valid;
    logic [JW-1:0]    job_data;

    sptrim_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sptrim_front #(
        .MAX_LEN (MAX_LEN),
        .CW      (CW),
        .AW      (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .q_full    (q_full),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_data (push_data)
    );

    sptrim_ram #(
        .WIDTH (8),
        .DEPTH (2 ** (AW + 1))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sptrim_jobq #(
        .W (JW)
    ) u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (job_valid),
        .head_data  (job_data)
    );

    sptrim_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .CW          (CW),
        .AW          (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_data  (job_data),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .text_out  (text_out)
    );

    a_bank_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && job_valid) |-> (wr_addr[AW] != job_data[JW-1]))
        else $error("front end wrote into the bank being trimmed");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> job_valid)
        else $error("job popped from an empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_out.valid && text_out.empty_result) |-> text_out.last_out)
        else $error("empty result not marked as the final transfer");

endmodule

`default_nettype wire
